// ----- hdl/orvl_pkg.sv -----
// Shared types and constants for the obstacle repulsion velocity limiter.
// No dependencies.
`timescale 1ns / 1ps

package orvl_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

  localparam logic [15:0] MARGIN_RST = 16'd1000;
  localparam logic [31:0] GAIN_RST   = 32'd500000;
  localparam logic [14:0] LIMIT_RST  = 15'd2000;

  localparam int DIV_Q_W   = 16;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;
  localparam int DIV_LAT   = DIV_Q_W + 1;

  localparam int ISQ_OUT_W = 18;
  localparam int ISQ_IN_W  = 2 * ISQ_OUT_W;
  localparam int ISQ_LAT   = ISQ_OUT_W + 1;

  localparam int NUM_SENSORS = 5;
  localparam int SEN_FRONT   = 0;
  localparam int SEN_BACK    = 1;
  localparam int SEN_UP      = 2;
  localparam int SEN_LEFT    = 3;
  localparam int SEN_RIGHT   = 4;

  localparam int SUM_W = 18;
  localparam int MAG_W = SUM_W - 1;

  localparam int PIPE_LAT = DIV_LAT + 2 + ISQ_LAT + 1 + DIV_LAT + 1;

  typedef struct packed {
    logic signed [15:0] want_x;
    logic signed [15:0] want_y;
    logic signed [15:0] want_z;
    logic [15:0]        range_front;
    logic [15:0]        range_back;
    logic [15:0]        range_up;
    logic [15:0]        range_left;
    logic [15:0]        range_right;
  } in_t;

  typedef struct packed {
    logic signed [15:0] cmd_x;
    logic signed [15:0] cmd_y;
    logic signed [15:0] cmd_z;
  } out_t;

endpackage

// ----- hdl/obstacle_repulsion_velocity_limit.sv -----
// Obstacle repulsion velocity limiter: range pushes, sum, speed limit.
// Path: A, push dividers, C, D, square root, F, scale dividers, out register.
// Throughput: one request per cycle; busy stays low, out_strobe is never stalled.
// Rate set by the pipelined dividers and square root, one bit per stage.
// Reset (synchronous, rst_n low) clears valid bits and loads register defaults.
// Depends on orvl_pkg, orvl_div, orvl_isqrt.
`timescale 1ns / 1ps

module obstacle_repulsion_velocity_limit import orvl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_data,
  output logic                  out_strobe,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0] margin_r;
  logic [31:0] gain_r;
  logic [14:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RST;
      gain_r   <= GAIN_RST;
      lim_r    <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MARGIN: margin_r <= cfg_wdata[15:0];
        CFG_GAIN:   gain_r   <= cfg_wdata;
        CFG_LIMIT:  lim_r    <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic acc;
  assign acc = start && !busy;

  // stage A: push numerator and denominator
  logic [15:0]          rng [0:NUM_SENSORS-1];
  logic [DIV_NUM_W-1:0] a_num_r [0:NUM_SENSORS-1];
  logic [DIV_DEN_W-1:0] a_den_r [0:NUM_SENSORS-1];
  logic [47:0]          a_want_r;
  logic                 a_v_r;

  assign rng[SEN_FRONT] = in_data.range_front;
  assign rng[SEN_BACK]  = in_data.range_back;
  assign rng[SEN_UP]    = in_data.range_up;
  assign rng[SEN_LEFT]  = in_data.range_left;
  assign rng[SEN_RIGHT] = in_data.range_right;

  for (genvar s = 0; s < NUM_SENSORS; s++) begin : g_push
    logic act;
    assign act = (rng[s] != 16'd0) && (rng[s] < margin_r);
    always_ff @(posedge clk) begin
      a_num_r[s] <= act ? (DIV_NUM_W'(gain_r) * DIV_NUM_W'(margin_r - rng[s]))
                        : '0;
      a_den_r[s] <= act ? (DIV_DEN_W'(rng[s]) * DIV_DEN_W'(margin_r))
                        : DIV_DEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    a_want_r <= {in_data.want_x, in_data.want_y, in_data.want_z};
    if (!rst_n) a_v_r <= 1'b0;
    else        a_v_r <= acc;
  end

  logic [DIV_Q_W-1:0] push [0:NUM_SENSORS-1];

  for (genvar s = 0; s < NUM_SENSORS; s++) begin : g_pdiv
    orvl_div u_div (
      .clk (clk),
      .num (a_num_r[s]),
      .den (a_den_r[s]),
      .quo (push[s])
    );
  end

  logic [47:0]        wd_r [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] vd_r;

  always_ff @(posedge clk) begin
    wd_r[0] <= a_want_r;
    for (int i = 1; i < DIV_LAT; i++) wd_r[i] <= wd_r[i-1];
    if (!rst_n) vd_r <= '0;
    else        vd_r <= {vd_r[DIV_LAT-2:0], a_v_r};
  end

  // stage C: apply pushes to the wanted velocity (front, left, up subtract; back, right add)
  logic signed [SUM_W-1:0] c_x_r, c_y_r, c_z_r;
  logic                    c_v_r;
  logic [47:0]             wv;

  assign wv = wd_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    c_x_r <= $signed({{2{wv[47]}}, wv[47:32]}) - $signed({2'b00, push[SEN_FRONT]})
           + $signed({2'b00, push[SEN_BACK]});
    c_y_r <= $signed({{2{wv[31]}}, wv[31:16]}) - $signed({2'b00, push[SEN_LEFT]})
           + $signed({2'b00, push[SEN_RIGHT]});
    c_z_r <= $signed({{2{wv[15]}}, wv[15:0]}) - $signed({2'b00, push[SEN_UP]});
    if (!rst_n) c_v_r <= 1'b0;
    else        c_v_r <= vd_r[DIV_LAT-1];
  end

  // stage D: squares
  logic [SUM_W-1:0]    nx, ny, nz;
  logic [MAG_W-1:0]    mx, my, mz;
  logic [ISQ_IN_W-1:0] d_sqx_r, d_sqy_r, d_sqz_r;
  logic [3*SUM_W-1:0]  d_sum_r;
  logic                d_v_r;

  always_comb begin
    nx = c_x_r[SUM_W-1] ? (SUM_W'(0) - c_x_r) : c_x_r;
    ny = c_y_r[SUM_W-1] ? (SUM_W'(0) - c_y_r) : c_y_r;
    nz = c_z_r[SUM_W-1] ? (SUM_W'(0) - c_z_r) : c_z_r;
    mx = nx[MAG_W-1:0];
    my = ny[MAG_W-1:0];
    mz = nz[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    d_sqx_r <= ISQ_IN_W'(mx) * ISQ_IN_W'(mx);
    d_sqy_r <= ISQ_IN_W'(my) * ISQ_IN_W'(my);
    d_sqz_r <= ISQ_IN_W'(mz) * ISQ_IN_W'(mz);
    d_sum_r <= {c_x_r, c_y_r, c_z_r};
    if (!rst_n) d_v_r <= 1'b0;
    else        d_v_r <= c_v_r;
  end

  logic [ISQ_OUT_W-1:0] spd;

  orvl_isqrt u_isqrt (
    .clk  (clk),
    .sq   (d_sqx_r + d_sqy_r + d_sqz_r),
    .root (spd)
  );

  logic [3*SUM_W-1:0] sd_r [0:ISQ_LAT-1];
  logic [ISQ_LAT-1:0] vs_r;

  always_ff @(posedge clk) begin
    sd_r[0] <= d_sum_r;
    for (int i = 1; i < ISQ_LAT; i++) sd_r[i] <= sd_r[i-1];
    if (!rst_n) vs_r <= '0;
    else        vs_r <= {vs_r[ISQ_LAT-2:0], d_v_r};
  end

  // stage F: scale products
  logic [3*SUM_W-1:0]   sv;
  logic                 scale;
  logic [DIV_NUM_W-1:0] f_num_r [0:2];
  logic [DIV_DEN_W-1:0] f_den_r;
  logic [3*SUM_W-1:0]   f_sum_r;
  logic                 f_scale_r;
  logic                 f_v_r;

  assign sv    = sd_r[ISQ_LAT-1];
  assign scale = (spd > ISQ_OUT_W'(lim_r));

  for (genvar a = 0; a < 3; a++) begin : g_prod
    logic [SUM_W-1:0] sa, na;
    assign sa = sv[(3-a)*SUM_W-1 -: SUM_W];
    assign na = sa[SUM_W-1] ? (SUM_W'(0) - sa) : sa;
    always_ff @(posedge clk) begin
      f_num_r[a] <= scale ? (DIV_NUM_W'(na[MAG_W-1:0]) * DIV_NUM_W'(lim_r)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    f_den_r   <= scale ? DIV_DEN_W'(spd) : DIV_DEN_W'(1);
    f_sum_r   <= sv;
    f_scale_r <= scale;
    if (!rst_n) f_v_r <= 1'b0;
    else        f_v_r <= vs_r[ISQ_LAT-1];
  end

  logic [DIV_Q_W-1:0] sq_q [0:2];

  for (genvar a = 0; a < 3; a++) begin : g_sdiv
    orvl_div u_div (
      .clk (clk),
      .num (f_num_r[a]),
      .den (f_den_r),
      .quo (sq_q[a])
    );
  end

  logic [3*SUM_W-1:0] gd_r [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] gs_r;
  logic [DIV_LAT-1:0] gv_r;

  always_ff @(posedge clk) begin
    gd_r[0] <= f_sum_r;
    for (int i = 1; i < DIV_LAT; i++) gd_r[i] <= gd_r[i-1];
    gs_r <= {gs_r[DIV_LAT-2:0], f_scale_r};
    if (!rst_n) gv_r <= '0;
    else        gv_r <= {gv_r[DIV_LAT-2:0], f_v_r};
  end

  // stage G: select and sign
  logic [3*SUM_W-1:0] gsum;
  logic               g_scale, g_v;
  logic [15:0]        cmd [0:2];
  out_t               out_r;
  logic               out_strobe_r;

  assign gsum    = gd_r[DIV_LAT-1];
  assign g_scale = gs_r[DIV_LAT-1];
  assign g_v     = gv_r[DIV_LAT-1];

  for (genvar a = 0; a < 3; a++) begin : g_out
    logic [SUM_W-1:0] sa;
    assign sa = gsum[(3-a)*SUM_W-1 -: SUM_W];
    assign cmd[a] = !g_scale ? sa[15:0]
                  : (sa[SUM_W-1] ? (16'd0 - sq_q[a]) : sq_q[a]);
  end

  always_ff @(posedge clk) begin
    out_r <= '{cmd_x: cmd[0], cmd_y: cmd[1], cmd_z: cmd[2]};
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= g_v;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LAT + 1))
    else $error("result without matching request");

  a_scaled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    g_v && g_scale |-> sq_q[0] <= DIV_Q_W'(lim_r) && sq_q[1] <= DIV_Q_W'(lim_r)
                       && sq_q[2] <= DIV_Q_W'(lim_r))
    else $error("scaled axis above speed limit");

  a_unscaled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    g_v && !g_scale |-> sq_q[0] == '0 && sq_q[1] == '0 && sq_q[2] == '0)
    else $error("scale divider out of step with its item");

endmodule

// ----- hdl/orvl_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// Depends on orvl_pkg.
`timescale 1ns / 1ps

module orvl_div import orvl_pkg::*; (
  input  logic                 clk,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_Q_W-1:0]   quo
);

  logic [DIV_NUM_W-1:0] rem_r [0:DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_r [0:DIV_Q_W];
  logic [DIV_Q_W-1:0]   q_r   [0:DIV_Q_W];
  logic                 sat_r [0:DIV_Q_W];

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    den_r[0] <= den;
    q_r[0]   <= '0;
    sat_r[0] <= (num >= {den, {DIV_Q_W{1'b0}}});
  end

  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
    logic [DIV_NUM_W-1:0] trial;
    logic                 ge;
    logic [DIV_Q_W-1:0]   q_nxt;

    always_comb begin
      trial = {{DIV_Q_W{1'b0}}, den_r[k]} << (DIV_Q_W - 1 - k);
      ge    = (rem_r[k] >= trial);
      q_nxt = q_r[k];
      q_nxt[DIV_Q_W-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? (rem_r[k] - trial) : rem_r[k];
      den_r[k+1] <= den_r[k];
      q_r[k+1]   <= q_nxt;
      sat_r[k+1] <= sat_r[k];
    end
  end

  assign quo = sat_r[DIV_Q_W] ? {DIV_Q_W{1'b1}} : q_r[DIV_Q_W];

endmodule

// ----- hdl/orvl_isqrt.sv -----
// Pipelined floor integer square root, one root bit per stage.
// Depends on orvl_pkg.
`timescale 1ns / 1ps

module orvl_isqrt import orvl_pkg::*; (
  input  logic                 clk,
  input  logic [ISQ_IN_W-1:0]  sq,
  output logic [ISQ_OUT_W-1:0] root
);

  logic [ISQ_IN_W-1:0]  n_r [0:ISQ_OUT_W];
  logic [ISQ_OUT_W-1:0] r_r [0:ISQ_OUT_W];

  always_ff @(posedge clk) begin
    n_r[0] <= sq;
    r_r[0] <= '0;
  end

  for (genvar k = 0; k < ISQ_OUT_W; k++) begin : g_step
    localparam int BIT = ISQ_OUT_W - 1 - k;
    logic [ISQ_IN_W-1:0] trial;
    logic                ge;
    logic [ISQ_OUT_W-1:0] r_nxt;

    always_comb begin
      trial = ({{(ISQ_IN_W-ISQ_OUT_W){1'b0}}, r_r[k]} << (BIT + 1))
            + ({{(ISQ_IN_W-1){1'b0}}, 1'b1} << (2 * BIT));
      ge    = (n_r[k] >= trial);
      r_nxt = r_r[k];
      r_nxt[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      n_r[k+1] <= ge ? (n_r[k] - trial) : n_r[k];
      r_r[k+1] <= r_nxt;
    end
  end

  assign root = r_r[ISQ_OUT_W];

endmodule

// ----- bench/orvl_checker.sv -----
// Checker for the obstacle repulsion velocity limiter: predicts each command
// from the request and its own register copy, and compares strobed results.
// Depends on orvl_pkg.
`timescale 1ns / 1ps

module orvl_checker import orvl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_t                   in_data,
  input  logic                  out_strobe,
  input  out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    pending,
  output int                    fails
);

  logic [15:0] margin;
  logic [31:0] gain;
  logic [14:0] limit;
  out_t        cmd_q[$];

  initial fails = 0;
  assign pending = cmd_q.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  function automatic longint push_for(input logic [15:0] d);
    longint unsigned q;
    if (d == 0 || d >= margin) return 0;
    q = (longint'(gain) * (margin - d)) / (longint'(d) * margin);
    return (q > 65535) ? 65535 : longint'(q);
  endfunction

  function automatic longint root_floor(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clamp_axis(input longint a, input longint lim, input longint spd);
    longint m;
    m = (a < 0) ? -a : a;
    m = (m * lim) / spd;
    return (a < 0) ? -m : m;
  endfunction

  function automatic out_t command_for(input in_t r);
    longint x, y, z, spd;
    out_t   c;
    x = longint'(r.want_x) - push_for(r.range_front) + push_for(r.range_back);
    z = longint'(r.want_z) - push_for(r.range_up);
    y = longint'(r.want_y) - push_for(r.range_left) + push_for(r.range_right);
    spd = root_floor(longint'(x * x + y * y + z * z));
    if (spd > limit && spd > 0) begin
      x = clamp_axis(x, limit, spd);
      y = clamp_axis(y, limit, spd);
      z = clamp_axis(z, limit, spd);
    end
    c.cmd_x = x[15:0];
    c.cmd_y = y[15:0];
    c.cmd_z = z[15:0];
    return c;
  endfunction

  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      margin <= MARGIN_RST;
      gain   <= GAIN_RST;
      limit  <= LIMIT_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MARGIN: margin <= cfg_wdata[15:0];
          CFG_GAIN:   gain   <= cfg_wdata;
          CFG_LIMIT:  limit  <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (start && !busy) cmd_q.push_back(command_for(in_data));
      if (out_strobe) begin
        if (cmd_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          e = cmd_q.pop_front();
          if (out_data.cmd_x !== e.cmd_x) report("cmd_x", out_data.cmd_x, e.cmd_x);
          if (out_data.cmd_y !== e.cmd_y) report("cmd_y", out_data.cmd_y, e.cmd_y);
          if (out_data.cmd_z !== e.cmd_z) report("cmd_z", out_data.cmd_z, e.cmd_z);
        end
      end
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the obstacle repulsion velocity limiter: drives requests
// and register writes, and gives the verdict. Depends on orvl_pkg, orvl_checker.
`timescale 1ns / 1ps

module tb_top;
  import orvl_pkg::*;

  localparam int DRAIN = PIPE_LAT + 20;
  localparam int LIMIT_CYCLES = 200000;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  start = 0;
  logic                  busy;
  in_t                   in_data = '0;
  logic                  out_strobe;
  out_t                  out_data;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    pending, fails;
  int                    cycles = 0;
  bit                    gaps = 1;
  logic [15:0]           cur_margin = MARGIN_RST;

  obstacle_repulsion_velocity_limit u_top (.*);

  orvl_checker u_chk (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(input in_t r);
    while (gaps && $urandom_range(99) < 27) begin
      start <= 0;
      @(posedge clk);
    end
    start   <= 1;
    in_data <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] m, input logic [31:0] g, input logic [14:0] l);
    drain();
    cfg_we <= 1; cfg_idx <= CFG_MARGIN; cfg_wdata <= {16'd0, m};
    @(posedge clk);
    cfg_idx <= CFG_GAIN; cfg_wdata <= g;
    @(posedge clk);
    cfg_idx <= CFG_LIMIT; cfg_wdata <= {17'd0, l};
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    cur_margin = m;
  endtask

  function automatic logic [15:0] pick_range();
    int k;
    k = $urandom_range(99);
    if (k < 20) return 0;
    if (k < 65 && cur_margin > 1) return 16'($urandom_range(cur_margin - 1, 1));
    if (k < 72) return 16'($urandom_range(3, 1));
    if (k < 78) return 16'hffff;
    return 16'($urandom);
  endfunction

  function automatic in_t rand_req();
    in_t r;
    r.want_x = ($urandom_range(3) == 0) ? 16'($urandom_range(300)) : 16'($urandom);
    r.want_y = 16'($urandom);
    r.want_z = ($urandom_range(3) == 0) ? -16'sd1 : 16'($urandom);
    r.range_front = pick_range();
    r.range_back  = pick_range();
    r.range_up    = pick_range();
    r.range_left  = pick_range();
    r.range_right = pick_range();
    return r;
  endfunction

  function automatic in_t mk(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                             input logic [15:0] f, input logic [15:0] b, input logic [15:0] u,
                             input logic [15:0] l, input logic [15:0] rt);
    in_t r;
    r = '{x, y, z, f, b, u, l, rt};
    return r;
  endfunction

  task automatic burst(input int n);
    repeat (n) send(rand_req());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: default registers first, then edge register settings
    send(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 0, 0));
    send(mk(16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0));
    send(mk(100, 200, 300, 0, 0, 0, 0, 0));
    send(mk(0, 0, 0, 1, 0, 0, 0, 0));
    send(mk(0, 0, 0, 0, 1, 0, 0, 0));
    send(mk(0, 0, 0, 0, 0, 1, 0, 0));
    send(mk(0, 0, 0, 0, 0, 0, 1, 0));
    send(mk(0, 0, 0, 0, 0, 0, 0, 1));
    send(mk(0, 0, 0, 999, 999, 999, 999, 999));
    send(mk(0, 0, 0, 1000, 1000, 1000, 1000, 1000));
    send(mk(0, 0, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send(mk(16'h7fff, 16'h7fff, 0, 0, 1, 0, 0, 1));
    send(mk(16'h8000, 16'h8000, 16'h8000, 1, 0, 1, 1, 0));
    send(mk(500, -16'sd300, 50, 300, 800, 0, 400, 999));
    set_regs(16'd0, 32'hffffffff, 15'd2000);
    send(mk(100, 100, 100, 1, 2, 3, 4, 5));
    send(mk(0, 0, 0, 16'hffff, 1, 0, 0, 0));
    set_regs(16'hffff, 32'hffffffff, 15'd0);
    send(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(1, 0, 0, 0, 0, 0, 0, 0));
    send(mk(0, 0, 0, 16'hfffe, 0, 0, 16'd40000, 0));
    set_regs(16'd1, 32'd0, 15'h7fff);
    send(mk(16'h8000, 16'h7fff, 16'h8000, 1, 1, 1, 1, 1));
    set_regs(16'd2, 32'd1, 15'd1);
    send(mk(16'h7fff, 0, 0, 1, 1, 1, 1, 1));
    // random
    set_regs(MARGIN_RST, GAIN_RST, LIMIT_RST);
    burst(250);
    gaps = 0;
    burst(150);
    gaps = 1;
    set_regs(16'hffff, 32'hffffffff, 15'h7fff);
    burst(200);
    set_regs(16'd0, 32'd12345, 15'd0);
    burst(80);
    set_regs(16'd1, 32'd0, 15'd1);
    burst(80);
    repeat (6) begin
      set_regs(16'($urandom_range(65535, 1)), $urandom, 15'($urandom));
      burst(100);
    end
    drain();
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
